[rtl/bfd_pkg.sv]
// Shared types, step codes and dither tables for the bilinear fit and dither block.
`timescale 1ns / 1ps
package bfd_pkg;

	localparam int DIV_NUM_W  = 32;
	localparam int DIV_DEN_W  = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int STEP_W     = 5;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIT_WIDTH     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIT_HEIGHT    = 2'd3;

	localparam logic [9:0] RST_SOURCE_WIDTH  = 10'd500;
	localparam logic [8:0] RST_SOURCE_HEIGHT = 9'd280;
	localparam logic [9:0] RST_FIT_WIDTH     = 10'd400;
	localparam logic [8:0] RST_FIT_HEIGHT    = 9'd220;

	// sequencer steps, also used as controller state codes
	localparam logic [STEP_W-1:0] ST_IDLE  = 5'd0;
	localparam logic [STEP_W-1:0] ST_FM1   = 5'd1;
	localparam logic [STEP_W-1:0] ST_FM2   = 5'd2;
	localparam logic [STEP_W-1:0] ST_FD1   = 5'd3;
	localparam logic [STEP_W-1:0] ST_FW1   = 5'd4;
	localparam logic [STEP_W-1:0] ST_FD2   = 5'd5;
	localparam logic [STEP_W-1:0] ST_FW2   = 5'd6;
	localparam logic [STEP_W-1:0] ST_FD3   = 5'd7;
	localparam logic [STEP_W-1:0] ST_FW3   = 5'd8;
	localparam logic [STEP_W-1:0] ST_CX    = 5'd9;
	localparam logic [STEP_W-1:0] ST_CY    = 5'd10;
	localparam logic [STEP_W-1:0] ST_CC    = 5'd11;
	localparam logic [STEP_W-1:0] ST_ADR   = 5'd12;
	localparam logic [STEP_W-1:0] ST_R00   = 5'd13;
	localparam logic [STEP_W-1:0] ST_R10   = 5'd14;
	localparam logic [STEP_W-1:0] ST_R01   = 5'd15;
	localparam logic [STEP_W-1:0] ST_R11   = 5'd16;
	localparam logic [STEP_W-1:0] ST_RLAST = 5'd17;
	localparam logic [STEP_W-1:0] ST_B0    = 5'd18;
	localparam logic [STEP_W-1:0] ST_B1    = 5'd19;
	localparam logic [STEP_W-1:0] ST_OUT   = 5'd20;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic              load;
		logic              fetch;
	} cmd_t;

	typedef struct packed {
		logic load_finishes;
		logic image_ready;
		logic scale;
		logic div_done;
		logic out_free;
	} stat_t;

	function automatic logic [2:0] dith_rb(input logic di, input logic dj);
		logic [2:0] r;
		case ({di, dj})
			2'b00:   r = 3'd0;
			2'b01:   r = 3'd3;
			2'b10:   r = 3'd5;
			default: r = 3'd1;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] dith_g(input logic di, input logic dj);
		logic [2:0] r;
		case ({di, dj})
			2'b01:   r = 3'd1;
			2'b10:   r = 3'd2;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/bilinear_fit_dither_rgb565.sv]
// Top level: bilinear fit-to-box downscaler with ordered dither and RGB565 output.
// A load item writes one source pixel; the load that completes the image holds the input
// while the output size and steps are computed (two multiplies and up to three divisions).
// A fetch item runs coordinate multiplies, four reads through the single source memory
// port and two blend stages, then waits until the output register is free to take it.
// An imageless fetch goes straight to output. Asynchronous active-low reset clears the
// control state and sets registers to 500, 280, 400, 220; the source store is not cleared.
`timescale 1ns / 1ps
module bilinear_fit_dither_rgb565 import bfd_pkg::*; #(
	parameter int MAX_SRC_W = 640,
	parameter int MAX_SRC_H = 480
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           pixel_rgb565,
	output logic [9:0]            out_x,
	output logic [8:0]            out_y,
	output logic [9:0]            out_width,
	output logic [8:0]            out_height,
	output logic                  last_pixel,
	output logic                  status
);

	cmd_t  cmd;
	stat_t stat;

	bfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.stat      (stat),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	bfd_dp #(
		.MAX_SRC_W (MAX_SRC_W),
		.MAX_SRC_H (MAX_SRC_H)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.pixel_rgb565 (pixel_rgb565),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_width    (out_width),
		.out_height   (out_height),
		.last_pixel   (last_pixel),
		.status       (status)
	);

endmodule

[rtl/bfd_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module bfd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 307200
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[rtl/bfd_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bfd_div import bfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   shifted;
	logic [DIV_DEN_W+1:0] diff;
	logic                 neg;

	assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign neg     = diff[DIV_DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= neg ? shifted[DIV_DEN_W-1:0] : diff[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ~neg};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

[rtl/bfd_dp.sv]
// Datapath: registers, source store, size and step math, sampling, dither and output register.
`timescale 1ns / 1ps
module bfd_dp import bfd_pkg::*; #(
	parameter int MAX_SRC_W = 640,
	parameter int MAX_SRC_H = 480
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [15:0]           pixel_rgb565,
	output logic [9:0]            out_x,
	output logic [8:0]            out_y,
	output logic [9:0]            out_width,
	output logic [8:0]            out_height,
	output logic                  last_pixel,
	output logic                  status
);

	localparam int WW    = $clog2(MAX_SRC_W + 1);
	localparam int HW    = $clog2(MAX_SRC_H + 1);
	localparam int DMW   = (WW > HW) ? WW : HW;
	localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int TW    = WW + HW;
	localparam int PW    = 10 + DMW;
	localparam int PRW   = 37;
	localparam int CRW   = DMW + 16;

	logic [9:0]  src_w_q;
	logic [8:0]  src_h_q;
	logic [9:0]  fit_w_q;
	logic [8:0]  fit_h_q;
	logic [CW-1:0] count_q;
	logic        ready_q;
	logic [9:0]  dw_q;
	logic [8:0]  dh_q;
	logic [9:0]  col_q;
	logic [8:0]  row_q;
	logic [25:0] col_step_q;
	logic [25:0] row_step_q;
	logic        wide_q;
	logic        nodata_q;
	logic [PW-1:0]  p1_q, p2_q;
	logic [PRW-1:0] prod_q;
	logic [CRW-1:0] sx_q, sy_q;
	logic [DMW-1:0] x0_q, x1_q;
	logic [15:0]    fx_q, fy_q;
	logic [AW-1:0]  row0_q, row1_q;
	logic [23:0]    p00_q, p10_q, p01_q, p11_q;
	logic [23:0]    r0_q [3];
	logic [23:0]    r1_q [3];
	logic [7:0]     chan_q [3];

	logic [WW-1:0] w_c;
	logic [HW-1:0] h_c;
	logic [9:0]    fw_c;
	logic [8:0]    fh_c;
	logic [TW-1:0] total;
	logic [CW-1:0] base, nxt;
	logic          scale, copy;
	logic          div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quot;
	logic [DIV_DEN_W-1:0] div_den;
	logic [AW-1:0]  ram_addr;
	logic [23:0]    ram_rdata;
	logic [DMW-1:0] x0_c, y0_c, x1_c, y1_c;
	logic [2*DMW-1:0] y0w, y1w;
	logic [9:0]     q_w;
	logic [8:0]     q_h;
	logic [23:0]    r0_d [3];
	logic [23:0]    r1_d [3];
	logic [7:0]     chan_d [3];
	logic [40:0]    v_d [3];
	logic [16:0]    wx0, wy0;
	logic [8:0]     r_sum, g_sum, b_sum;
	logic [7:0]     r_sat, g_sat, b_sat;
	logic           out_load;
	logic           last_c;

	function automatic logic [CRW-1:0] clamp_coord(input logic [PRW-1:0] p,
		input logic [DMW-1:0] sz);
		logic signed [PRW+1:0] s;
		logic signed [PRW+1:0] hi;
		logic [DMW-1:0]        szm;
		logic [CRW-1:0]        r;
		szm = sz - 1'b1;
		s   = $signed({2'b00, p >> 1}) - $signed((PRW+2)'(32768));
		hi  = $signed((PRW+2)'({szm, 16'h0000}));
		if (s < 0) begin
			r = '0;
		end else if (s > hi) begin
			r = hi[CRW-1:0];
		end else begin
			r = s[CRW-1:0];
		end
		return r;
	endfunction

	// effective source and box sizes
	always_comb begin
		if (src_w_q == '0) begin
			w_c = WW'(1);
		end else if ({6'b0, src_w_q} > 16'(MAX_SRC_W)) begin
			w_c = WW'(MAX_SRC_W);
		end else begin
			w_c = WW'(src_w_q);
		end
		if (src_h_q == '0) begin
			h_c = HW'(1);
		end else if ({7'b0, src_h_q} > 16'(MAX_SRC_H)) begin
			h_c = HW'(MAX_SRC_H);
		end else begin
			h_c = HW'(src_h_q);
		end
		fw_c = (fit_w_q == '0) ? 10'd1 : fit_w_q;
		fh_c = (fit_h_q == '0) ? 9'd1 : fit_h_q;
	end

	assign total = TW'(w_c) * TW'(h_c);
	assign base  = ready_q ? '0 : count_q;
	assign nxt   = base + 1'b1;
	assign scale = (16'(w_c) > 16'(fw_c)) || (16'(h_c) > 16'(fh_c));
	assign copy  = (16'(dw_q) == 16'(w_c)) && (16'(dh_q) == 16'(h_c));

	// divider operands per step
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd.step)
			ST_FD1: begin
				div_start = scale;
				if (p1_q <= p2_q) begin
					div_num = DIV_NUM_W'({p1_q, 1'b0}) + DIV_NUM_W'(w_c);
					div_den = DIV_DEN_W'({w_c, 1'b0});
				end else begin
					div_num = DIV_NUM_W'({p2_q, 1'b0}) + DIV_NUM_W'(h_c);
					div_den = DIV_DEN_W'({h_c, 1'b0});
				end
			end
			ST_FD2: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'({w_c, 16'h0000});
				div_den   = DIV_DEN_W'(dw_q);
			end
			ST_FD3: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'({h_c, 16'h0000});
				div_den   = DIV_DEN_W'(dh_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	bfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign q_w = (div_quot[9:0] == '0) ? 10'd1 : div_quot[9:0];
	assign q_h = (div_quot[8:0] == '0) ? 9'd1 : div_quot[8:0];

	// neighbor positions
	always_comb begin
		x0_c = sx_q[CRW-1:16];
		y0_c = sy_q[CRW-1:16];
		x1_c = (16'(x0_c) + 16'd1 < 16'(w_c)) ? x0_c + 1'b1 : x0_c;
		y1_c = (16'(y0_c) + 16'd1 < 16'(h_c)) ? y0_c + 1'b1 : y0_c;
		y0w  = (2*DMW)'(y0_c) * (2*DMW)'(w_c);
		y1w  = (2*DMW)'(y1_c) * (2*DMW)'(w_c);
	end

	always_comb begin
		case (cmd.step)
			ST_R00:  ram_addr = row0_q + AW'(x0_q);
			ST_R10:  ram_addr = row0_q + AW'(x1_q);
			ST_R01:  ram_addr = row1_q + AW'(x0_q);
			ST_R11:  ram_addr = row1_q + AW'(x1_q);
			default: ram_addr = base[AW-1:0];
		endcase
	end

	bfd_ram #(
		.WIDTH (24),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.load),
		.addr  (ram_addr),
		.wdata ({red, green, blue}),
		.rdata (ram_rdata)
	);

	// blend: rows along x first, then along y; exact before the final rounding
	always_comb begin
		wx0 = 17'h10000 - {1'b0, fx_q};
		wy0 = 17'h10000 - {1'b0, fy_q};
		for (int c = 0; c < 3; c++) begin
			r0_d[c] = 24'(wx0) * 24'(p00_q[8*c +: 8]) + 24'(fx_q) * 24'(p10_q[8*c +: 8]);
			r1_d[c] = 24'(wx0) * 24'(p01_q[8*c +: 8]) + 24'(fx_q) * 24'(p11_q[8*c +: 8]);
			v_d[c]  = 41'(wy0) * 41'(r0_q[c]) + 41'(fy_q) * 41'(r1_q[c])
			        + 41'h0_8000_0000;
			chan_d[c] = v_d[c][39:32];
		end
	end

	// dither and pack
	always_comb begin
		r_sum = {1'b0, chan_q[2]} + 9'(dith_rb(row_q[0], col_q[0]));
		g_sum = {1'b0, chan_q[1]} + 9'(dith_g(row_q[0], col_q[0]));
		b_sum = {1'b0, chan_q[0]} + 9'(dith_rb(row_q[0], col_q[0]));
		r_sat = r_sum[8] ? 8'hFF : r_sum[7:0];
		g_sat = g_sum[8] ? 8'hFF : g_sum[7:0];
		b_sat = b_sum[8] ? 8'hFF : b_sum[7:0];
		last_c = (11'(col_q) + 11'd1 >= 11'(dw_q)) && (10'(row_q) + 10'd1 >= 10'(dh_q));
	end

	assign out_load = (cmd.step == ST_OUT) && (!out_valid || out_ready);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q    <= RST_SOURCE_WIDTH;
			src_h_q    <= RST_SOURCE_HEIGHT;
			fit_w_q    <= RST_FIT_WIDTH;
			fit_h_q    <= RST_FIT_HEIGHT;
			count_q    <= '0;
			ready_q    <= 1'b0;
			dw_q       <= '0;
			dh_q       <= '0;
			col_q      <= '0;
			row_q      <= '0;
			col_step_q <= '0;
			row_step_q <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SOURCE_WIDTH:  src_w_q <= cfg_data;
					REG_SOURCE_HEIGHT: src_h_q <= cfg_data[8:0];
					REG_FIT_WIDTH:     fit_w_q <= cfg_data;
					REG_FIT_HEIGHT:    fit_h_q <= cfg_data[8:0];
					default:           src_w_q <= src_w_q;
				endcase
				count_q <= '0;
				ready_q <= 1'b0;
			end
			if (cmd.load) begin
				count_q <= nxt;
				ready_q <= 1'b0;
			end
			case (cmd.step)
				ST_FD1: begin
					if (!scale) begin
						dw_q <= 10'(w_c);
						dh_q <= 9'(h_c);
					end else if (p1_q <= p2_q) begin
						dw_q <= fw_c;
					end else begin
						dh_q <= fh_c;
					end
				end
				ST_FW1: begin
					if (div_done) begin
						if (wide_q) begin
							dh_q <= q_h;
						end else begin
							dw_q <= q_w;
						end
					end
				end
				ST_FW2: begin
					if (div_done) begin
						col_step_q <= div_quot[25:0];
					end
				end
				ST_FW3: begin
					if (div_done) begin
						row_step_q <= div_quot[25:0];
						col_q      <= '0;
						row_q      <= '0;
						ready_q    <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid <= 1'b1;
				if (!nodata_q) begin
					if (11'(col_q) + 11'd1 < 11'(dw_q)) begin
						col_q <= col_q + 1'b1;
					end else begin
						col_q <= '0;
						row_q <= (10'(row_q) + 10'd1 < 10'(dh_q)) ? row_q + 1'b1 : '0;
					end
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			nodata_q <= !ready_q;
		end
		case (cmd.step)
			ST_FM1: p1_q <= PW'(fw_c) * PW'(h_c);
			ST_FM2: p2_q <= PW'(fh_c) * PW'(w_c);
			ST_FD1: wide_q <= (p1_q <= p2_q);
			ST_CX:  prod_q <= PRW'({col_q, 1'b1}) * PRW'(col_step_q);
			ST_CY: begin
				sx_q   <= clamp_coord(prod_q, DMW'(w_c));
				prod_q <= PRW'({row_q, 1'b1}) * PRW'(row_step_q);
			end
			ST_CC: begin
				if (copy) begin
					sx_q <= CRW'({col_q, 16'h0000});
					sy_q <= CRW'({row_q, 16'h0000});
				end else begin
					sy_q <= clamp_coord(prod_q, DMW'(h_c));
				end
			end
			ST_ADR: begin
				x0_q   <= x0_c;
				x1_q   <= x1_c;
				fx_q   <= sx_q[15:0];
				fy_q   <= sy_q[15:0];
				row0_q <= AW'(y0w);
				row1_q <= AW'(y1w);
			end
			ST_R10:   p00_q <= ram_rdata;
			ST_R01:   p10_q <= ram_rdata;
			ST_R11:   p01_q <= ram_rdata;
			ST_RLAST: p11_q <= ram_rdata;
			ST_B0: begin
				for (int c = 0; c < 3; c++) begin
					r0_q[c] <= r0_d[c];
					r1_q[c] <= r1_d[c];
				end
			end
			ST_B1: begin
				for (int c = 0; c < 3; c++) begin
					chan_q[c] <= chan_d[c];
				end
			end
			default: begin
				p1_q <= p1_q;
			end
		endcase
		if (out_load) begin
			if (nodata_q) begin
				pixel_rgb565 <= '0;
				out_x        <= '0;
				out_y        <= '0;
				out_width    <= '0;
				out_height   <= '0;
				last_pixel   <= 1'b0;
				status       <= 1'b1;
			end else begin
				pixel_rgb565 <= {r_sat[7:3], g_sat[7:2], b_sat[7:3]};
				out_x        <= col_q;
				out_y        <= row_q;
				out_width    <= dw_q;
				out_height   <= dh_q;
				last_pixel   <= last_c;
				status       <= 1'b0;
			end
		end
	end

	assign stat.load_finishes = TW'(nxt) >= total;
	assign stat.image_ready   = ready_q;
	assign stat.scale         = scale;
	assign stat.div_done      = div_done;
	assign stat.out_free      = !out_valid || out_ready;

endmodule

[rtl/bfd_ctrl.sv]
// Controller: sequences loads, image finishing and pixel fetches.
`timescale 1ns / 1ps
module bfd_ctrl import bfd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  operation,
	input  stat_t stat,
	output logic  in_ready,
	output cmd_t  cmd
);

	logic [STEP_W-1:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd.step  = state_q;
		cmd.load  = 1'b0;
		cmd.fetch = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!operation) begin
						cmd.load = 1'b1;
						if (stat.load_finishes) begin
							state_d = ST_FM1;
						end
					end else begin
						cmd.fetch = 1'b1;
						state_d   = stat.image_ready ? ST_CX : ST_OUT;
					end
				end
			end
			ST_FM1:   state_d = ST_FM2;
			ST_FM2:   state_d = ST_FD1;
			ST_FD1:   state_d = stat.scale ? ST_FW1 : ST_FD2;
			ST_FW1:   state_d = stat.div_done ? ST_FD2 : ST_FW1;
			ST_FD2:   state_d = ST_FW2;
			ST_FW2:   state_d = stat.div_done ? ST_FD3 : ST_FW2;
			ST_FD3:   state_d = ST_FW3;
			ST_FW3:   state_d = stat.div_done ? ST_IDLE : ST_FW3;
			ST_CX:    state_d = ST_CY;
			ST_CY:    state_d = ST_CC;
			ST_CC:    state_d = ST_ADR;
			ST_ADR:   state_d = ST_R00;
			ST_R00:   state_d = ST_R10;
			ST_R10:   state_d = ST_R01;
			ST_R01:   state_d = ST_R11;
			ST_R11:   state_d = ST_RLAST;
			ST_RLAST: state_d = ST_B0;
			ST_B0:    state_d = ST_B1;
			ST_B1:    state_d = ST_OUT;
			// hold until the output register is free
			ST_OUT:   state_d = stat.out_free ? ST_IDLE : ST_OUT;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/bfd_chk.sv]
// Port-level checker for the top level, attached by bind.
`timescale 1ns / 1ps
module bfd_chk import bfd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  operation,
	input logic [7:0]            red,
	input logic [7:0]            green,
	input logic [7:0]            blue,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [15:0]           pixel_rgb565,
	input logic [9:0]            out_x,
	input logic [8:0]            out_y,
	input logic [9:0]            out_width,
	input logic [8:0]            out_height,
	input logic                  last_pixel,
	input logic                  status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_rgb565) && $stable(out_x))
		else $error("stalled item changed");

	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> pixel_rgb565 == 16'd0 && out_width == 10'd0 && !last_pixel)
		else $error("no-image item carries data");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> out_x < out_width && out_y < out_height)
		else $error("pixel position outside output size");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status && last_pixel |->
		out_x + 11'd1 == 11'(out_width) && out_y + 10'd1 == 10'(out_height))
		else $error("last pixel flag at wrong position");

endmodule

bind bilinear_fit_dither_rgb565 bfd_chk u_chk (.*);

[test/tb.sv]
// Testbench for bilinear_fit_dither_rgb565: directed and random loads and fetches checked against a local predictor.
`timescale 1ns / 1ps
module tb;
	import bfd_pkg::*;

	localparam int STORE_N   = 640 * 480;
	localparam int WDOG_MAX  = 3000;
	localparam int SETTLE    = 150;

	typedef enum logic {OP_LOAD = 1'b0, OP_FETCH = 1'b1} op_e;

	typedef struct packed {
		logic [15:0] pix;
		logic [9:0]  x;
		logic [8:0]  y;
		logic [9:0]  w;
		logic [8:0]  h;
		logic        last;
		logic        status;
	} pixel_res_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready, operation;
	logic [7:0] red, green, blue;
	logic out_valid, out_ready;
	logic [15:0] pixel_rgb565;
	logic [9:0] out_x, out_width;
	logic [8:0] out_y, out_height;
	logic last_pixel, status;

	bilinear_fit_dither_rgb565 dut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// predictor state
	logic [23:0] src_pix [STORE_N];
	logic [9:0]  reg_sw, reg_fw;
	logic [8:0]  reg_sh, reg_fh;
	int unsigned loaded;
	bit          img_ok;
	int unsigned dst_w, dst_h, col_pos, row_pos;
	longint unsigned step_x, step_y;

	pixel_res_t  pending_pix [$];
	int          err_count;
	int          items_sent;
	int          send_idle_pct, recv_stall_pct;
	bit          hold_req;
	int          quiet_cycles;

	function automatic int unsigned eff_w();
		return (reg_sw == 0) ? 1 : (reg_sw > 640 ? 640 : reg_sw);
	endfunction

	function automatic int unsigned eff_h();
		return (reg_sh == 0) ? 1 : (reg_sh > 480 ? 480 : reg_sh);
	endfunction

	function automatic void fix_size();
		longint unsigned w, h, fw, fh, dw, dh;
		w = eff_w(); h = eff_h();
		fw = (reg_fw == 0) ? 1 : reg_fw;
		fh = (reg_fh == 0) ? 1 : reg_fh;
		dw = w; dh = h;
		if (w > fw || h > fh) begin
			if (fw * h <= fh * w) begin
				dw = fw;
				dh = (2 * h * fw + w) / (2 * w);
			end else begin
				dh = fh;
				dw = (2 * w * fh + h) / (2 * h);
			end
			if (dw < 1) dw = 1;
			if (dh < 1) dh = 1;
		end
		dst_w = 32'(dw); dst_h = 32'(dh);
		step_x = ((w << 16) / dw) & 64'h3FFFFFF;
		step_y = ((h << 16) / dh) & 64'h3FFFFFF;
		col_pos = 0; row_pos = 0;
		img_ok = 1;
	endfunction

	function automatic longint unsigned centered(int unsigned i, longint unsigned stp,
			int unsigned n);
		longint s, top;
		s = longint'(((longint'(i) * 2 + 1) * stp) >> 1) - 32768;
		top = longint'(n - 1) << 16;
		if (s < 0) s = 0;
		if (s > top) s = top;
		return s;
	endfunction

	function automatic logic [23:0] blend_at(int unsigned ox, int unsigned oy);
		int unsigned w, h, x0, y0, x1, y1;
		longint unsigned sx, sy, fx, fy, w00, w10, w01, w11, v, c;
		logic [23:0] p00, p10, p01, p11, rgb;
		w = eff_w(); h = eff_h();
		sx = centered(ox, step_x, w);
		sy = centered(oy, step_y, h);
		x0 = 32'(sx >> 16); y0 = 32'(sy >> 16);
		fx = sx & 16'hFFFF; fy = sy & 16'hFFFF;
		x1 = (x0 + 1 < w) ? x0 + 1 : x0;
		y1 = (y0 + 1 < h) ? y0 + 1 : y0;
		p00 = src_pix[y0 * w + x0]; p10 = src_pix[y0 * w + x1];
		p01 = src_pix[y1 * w + x0]; p11 = src_pix[y1 * w + x1];
		w00 = (65536 - fx) * (65536 - fy); w10 = fx * (65536 - fy);
		w01 = (65536 - fx) * fy;           w11 = fx * fy;
		for (int sh = 0; sh < 24; sh += 8) begin
			v = w00 * p00[sh+:8] + w10 * p10[sh+:8] + w01 * p01[sh+:8] + w11 * p11[sh+:8];
			c = (v + 64'h80000000) >> 32;
			if (c > 255) c = 255;
			rgb[sh+:8] = c[7:0];
		end
		return rgb;
	endfunction

	function automatic int unsigned dith_rb_val(bit di, bit dj);
		case ({di, dj})
			2'b00: return 0;
			2'b01: return 3;
			2'b10: return 5;
			default: return 1;
		endcase
	endfunction

	function automatic int unsigned dith_g_val(bit di, bit dj);
		case ({di, dj})
			2'b01: return 1;
			2'b10: return 2;
			default: return 0;
		endcase
	endfunction

	// advance the predictor by one accepted item
	function automatic void predict_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_res_t e;
		logic [23:0] rgb;
		int unsigned rr, gg, bb, drb, dg, total;
		if (op == OP_LOAD) begin
			total = eff_w() * eff_h();
			if (img_ok) begin
				img_ok = 0;
				loaded = 0;
			end
			if (loaded < total) begin
				src_pix[loaded] = {r, g, b};
				loaded++;
			end
			if (loaded >= total) fix_size();
			return;
		end
		e = '{default: '0};
		if (!img_ok) begin
			e.status = 1'b1;
			pending_pix.insert(pending_pix.size(), e);
			return;
		end
		if (dst_w == eff_w() && dst_h == eff_h()) rgb = src_pix[row_pos * eff_w() + col_pos];
		else rgb = blend_at(col_pos, row_pos);
		drb = dith_rb_val(row_pos[0], col_pos[0]);
		dg  = dith_g_val(row_pos[0], col_pos[0]);
		rr = rgb[23:16] + drb; if (rr > 255) rr = 255;
		gg = rgb[15:8] + dg;   if (gg > 255) gg = 255;
		bb = rgb[7:0] + drb;   if (bb > 255) bb = 255;
		e.pix  = {rr[7:3], gg[7:2], bb[7:3]};
		e.x    = 10'(col_pos);
		e.y    = 9'(row_pos);
		e.w    = 10'(dst_w);
		e.h    = 9'(dst_h);
		e.last = (col_pos + 1 >= dst_w && row_pos + 1 >= dst_h);
		pending_pix.insert(pending_pix.size(), e);
		if (col_pos + 1 < dst_w) col_pos++;
		else begin
			col_pos = 0;
			row_pos = (row_pos + 1 < dst_h) ? row_pos + 1 : 0;
		end
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1; operation = op; red = r; green = g; blue = b;
		do @(posedge clk); while (!in_ready);
		predict_item(op, r, g, b);
		items_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_load(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		send_item(OP_LOAD, r, g, b);
	endtask

	task automatic send_fetch();
		send_item(OP_FETCH, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(3))
			0: return 8'($urandom_range(255, 248));
			1: return 8'($urandom_range(7));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic load_image(int unsigned n);
		repeat (n) send_load(rand_chan(), rand_chan(), rand_chan());
	endtask

	// write only while idle: drain results, then let a size computation finish
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		wait (pending_pix.size() == 0);
		repeat (SETTLE) @(negedge clk);
		cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_SOURCE_WIDTH:  reg_sw = val;
			REG_SOURCE_HEIGHT: reg_sh = val[8:0];
			REG_FIT_WIDTH:     reg_fw = val;
			default:           reg_fh = val[8:0];
		endcase
		loaded = 0;
		img_ok = 0;
	endtask

	task automatic set_geometry(int sw, int sh, int fw, int fh);
		write_reg(REG_SOURCE_WIDTH, CFG_DATA_W'(sw));
		write_reg(REG_SOURCE_HEIGHT, CFG_DATA_W'(sh));
		write_reg(REG_FIT_WIDTH, CFG_DATA_W'(fw));
		write_reg(REG_FIT_HEIGHT, CFG_DATA_W'(fh));
	endtask

	task automatic test_no_image();
		send_fetch();
		send_load(8'hFF, 8'h00, 8'hAA);
		send_fetch();
	endtask

	task automatic test_directed();
		// copy path with corner values, fetch past the end to wrap
		set_geometry(3, 2, 640, 480);
		send_load(8'h00, 8'h00, 8'h00);
		send_load(8'hFF, 8'hFF, 8'hFF);
		send_fetch();
		send_load(8'hFC, 8'hFE, 8'hFD);
		send_load(8'h55, 8'hAA, 8'h55);
		send_load(8'hAA, 8'h55, 8'hAA);
		send_load(8'hFB, 8'hFF, 8'hFA);
		repeat (8) send_fetch();
		// load after a full image starts a new one
		send_load(8'h01, 8'h02, 8'h03);
		send_fetch();
		load_image(5);
		repeat (3) send_fetch();
		// scaled path
		set_geometry(8, 4, 4, 4);
		load_image(32);
		repeat (9) send_fetch();
	endtask

	task automatic test_extremes();
		set_geometry(1023, 1, 1, 0);
		load_image(640);
		repeat (3) send_fetch();
		set_geometry(0, 3, 640, 0);
		load_image(3);
		repeat (3) send_fetch();
		set_geometry(1, 7, 1023, 511);
		load_image(7);
		repeat (4) send_fetch();
		set_geometry(5, 1, 1023, 1023);
		load_image(5);
		repeat (4) send_fetch();
	endtask

	task automatic test_random_images(int quota);
		int stop_at, w, h, n;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			w = $urandom_range(20, 1);
			h = $urandom_range(12, 1);
			if ($urandom_range(2) == 0) set_geometry(w, h, w + $urandom_range(4), h + $urandom_range(4));
			else set_geometry(w, h, $urandom_range(24, 1), $urandom_range(16, 1));
			n = w * h;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(19) == 0) send_fetch();
				send_load(rand_chan(), rand_chan(), rand_chan());
			end
			repeat ($urandom_range(n + 4, 1)) send_fetch();
			if ($urandom_range(4) == 0) begin
				load_image($urandom_range(n, 1));
				repeat (2) send_fetch();
			end
		end
	endtask

	task automatic test_backpressure();
		set_geometry(6, 5, 4, 4);
		load_image(30);
		hold_req = 1'b1;
		repeat (40) send_fetch();
		// pause until every result is back
		wait (pending_pix.size() == 0);
		@(negedge clk);
		repeat (10) send_fetch();
	endtask

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			hold_req = 1'b0;
			repeat (300) @(negedge clk);
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pixel_res_t e, got;
		if (arst_n && out_valid && out_ready) begin
			got = '{pixel_rgb565, out_x, out_y, out_width, out_height, last_pixel, status};
			if (pending_pix.size() == 0) begin
				$display("%0t: unexpected result pix=%h x=%0d y=%0d", $time, got.pix, got.x, got.y);
				err_count++;
			end else begin
				e = pending_pix.pop_front();
				if (got != e) begin
					$display("%0t: mismatch exp pix=%h x=%0d y=%0d w=%0d h=%0d last=%0d st=%0d",
						$time, e.pix, e.x, e.y, e.w, e.h, e.last, e.status);
					$display("%0t:          got pix=%h x=%0d y=%0d w=%0d h=%0d last=%0d st=%0d",
						$time, got.pix, got.x, got.y, got.w, got.h, got.last, got.status);
					err_count++;
				end
			end
		end
	end

	// watchdog: cycles with no handshake on either channel and no register write
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; operation = 1'b0; red = '0; green = '0; blue = '0;
		hold_req = 1'b0; quiet_cycles = 0;
		err_count = 0; items_sent = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		reg_sw = RST_SOURCE_WIDTH; reg_sh = RST_SOURCE_HEIGHT;
		reg_fw = RST_FIT_WIDTH; reg_fh = RST_FIT_HEIGHT;
		loaded = 0; img_ok = 0; dst_w = 0; dst_h = 0;
		col_pos = 0; row_pos = 0; step_x = 0; step_y = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_no_image();
		test_directed();
		test_extremes();
		test_random_images(150);
		send_idle_pct = 68;
		test_random_images(150);
		send_idle_pct = 0; recv_stall_pct = 68;
		test_random_images(150);
		send_idle_pct = 8; recv_stall_pct = 8;
		test_random_images(150);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_backpressure();

		wait (pending_pix.size() == 0);
		repeat (SETTLE) @(negedge clk);
		if (err_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
